[sv/stsp_pkg.sv]
// ----------------------------------------------------------------------------
// Stepper segment planner package
// Shared codes, widths and profile defaults for the planner block.
// ----------------------------------------------------------------------------
package stsp_pkg;

    // defaults for the top-level parameters
    localparam int PULSE_CLOCK_HZ_DEF    = 1000000;
    localparam int CONTROL_HZ_DEF        = 100;
    localparam int MAX_SEGMENT_STEPS_DEF = 160;
    localparam int MIN_STEP_RATE_DEF     = 1;
    localparam int MAX_STEP_RATE_DEF     = 16000;

    // serial divider operand widths
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 25;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [2:0] {
        CFG_START_RATE   = 3'd0,
        CFG_MAX_RATE     = 3'd1,
        CFG_ACCELERATION = 3'd2,
        CFG_MOTOR_EN     = 3'd3,
        CFG_POS_KNOWN    = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_MOVE_TO      = 3'd0,
        OP_MOVE_BY      = 3'd1,
        OP_STOP         = 3'd2,
        OP_ESTOP        = 3'd3,
        OP_SEGMENT_DONE = 3'd4,
        OP_SET_POSITION = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BUSY      = 3'd1,
        ST_INVALID   = 3'd2,
        ST_DISABLED  = 3'd3,
        ST_NOT_READY = 3'd4,
        ST_IGNORED   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        M_DISABLED = 2'd0,
        M_READY    = 2'd1,
        M_MOVING   = 2'd2,
        M_STOPPING = 2'd3
    } t_mode;

endpackage

[sv/stsp_in_if.sv]
// ----------------------------------------------------------------------------
// Planner event channel
// Valid/ready channel carrying one motion event per transaction.
// ----------------------------------------------------------------------------
interface stsp_in_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  op;
    logic signed [31:0] target_position;
    logic signed [31:0] step_offset;
    logic        [7:0]  partial_steps;

    modport source (output valid, output op, output target_position,
                    output step_offset, output partial_steps, input ready);
    modport sink   (input valid, input op, input target_position,
                    input step_offset, input partial_steps, output ready);
endinterface

[sv/stsp_out_if.sv]
// ----------------------------------------------------------------------------
// Planner result channel
// Valid/ready channel carrying one planner result per transaction.
// ----------------------------------------------------------------------------
interface stsp_out_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  status;
    logic        [1:0]  motor_state;
    logic               direction;
    logic               segment_start;
    logic        [7:0]  segment_steps;
    logic        [16:0] period_ticks;
    logic        [15:0] step_rate;
    logic signed [31:0] position;
    logic signed [31:0] target;

    modport source (output valid, output status, output motor_state, output direction,
                    output segment_start, output segment_steps, output period_ticks,
                    output step_rate, output position, output target, input ready);
    modport sink   (input valid, input status, input motor_state, input direction,
                    input segment_start, input segment_steps, input period_ticks,
                    input step_rate, input position, input target, output ready);
endinterface

[sv/stsp_div.sv]
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module stsp_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [stsp_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [stsp_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                            o_done,
    output logic [stsp_pkg::DIV_NUM_W-1:0]  o_quot
);
    import stsp_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] r_sh;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   n_trial;
    logic                 n_ge;

    // shift in next dividend bit and trial-subtract
    always_comb begin
        n_trial = {r_rem[DIV_DEN_W-1:0], r_sh[DIV_NUM_W-1]};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_sh   <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(DIV_NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_ge ? (n_trial - {1'b0, r_den}) : n_trial;
                r_sh  <= {r_sh[DIV_NUM_W-2:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule

[sv/stepper_trapezoid_segment_planner_unit.sv]
// ----------------------------------------------------------------------------
// Stepper trapezoid segment planner
// Plans trapezoidal stepper moves as pulse segments with a serial divider.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake    | contents
//  i_in     | in        | valid/ready  | op, target, offset, partial steps
//  o_out    | out       | valid/ready  | status, mode, segment, rate, position
//  i_cfg_*  | in        | write enable | profile and enable registers
//
//  Each division on the shared bit-serial divider loads its operands, forms
//  the 40 quotient bits and signals done. A plain event needs no division,
//  a move that launches a segment needs two (pulse count, period), and a
//  segment end up to four (rate step, braking distance, pulse count, period).
//  Reset is synchronous; all planner state returns to its reset values.
//  A new event is taken once the previous one has left the datapath; the
//  output register lets it proceed while the last result waits, and the
//  planner holds in its output state while that register is still full.
// ----------------------------------------------------------------------------
module stepper_trapezoid_segment_planner_unit #(
    parameter int PULSE_CLOCK_HZ    = stsp_pkg::PULSE_CLOCK_HZ_DEF,
    parameter int CONTROL_HZ        = stsp_pkg::CONTROL_HZ_DEF,
    parameter int MAX_SEGMENT_STEPS = stsp_pkg::MAX_SEGMENT_STEPS_DEF,
    parameter int MIN_STEP_RATE     = stsp_pkg::MIN_STEP_RATE_DEF,
    parameter int MAX_STEP_RATE     = stsp_pkg::MAX_STEP_RATE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [stsp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [stsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    stsp_in_if.sink                          i_in,
    stsp_out_if.source                       o_out
);
    import stsp_pkg::*;

    localparam int HALF_CTL = CONTROL_HZ / 2;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SD_CHK, S_DLT_MUL, S_DLT_DIV, S_DLT_USE,
        S_BRK_MUL, S_BRK_DIV, S_BRK_USE, S_LN_GO, S_LN_CNT, S_LN_PER, S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [15:0] r_start_rate, r_max_rate;
    logic [23:0] r_accel;
    logic        r_en, r_known;

    // planner state
    t_mode       r_mode;
    logic [31:0] r_pos, r_tgt;
    logic        r_dir, r_stop, r_run;
    logic [15:0] r_rate, r_p_start, r_p_max;
    logic [23:0] r_p_accel;
    logic [7:0]  r_seg_len;

    // event and work registers
    logic [2:0]  r_op;
    logic [31:0] r_tpos, r_offs;
    logic [7:0]  r_part;
    t_status     r_status;
    logic        r_started;
    logic [7:0]  r_steps;
    logic [16:0] r_period;
    logic [31:0] r_prod, r_delta, r_sq_rate, r_sq_start;
    logic [32:0] r_bd;

    // divider handshake
    logic                 r_div_go;
    logic [DIV_NUM_W-1:0] r_div_num;
    logic [DIV_DEN_W-1:0] r_div_den;
    logic                 w_div_done;
    logic [DIV_NUM_W-1:0] w_quot;

    // output register
    logic        r_ov;
    t_status     r_o_status;
    t_mode       r_o_mode;
    logic        r_o_dir, r_o_start;
    logic [7:0]  r_o_steps;
    logic [16:0] r_o_period;
    logic [15:0] r_o_rate;
    logic [31:0] r_o_pos, r_o_tgt;

    // combinational helpers
    logic        n_en, n_known;
    t_mode       w_idle_mode, n_cfg_idle_mode;
    logic        w_busy;
    logic [32:0] w_diff;
    logic [31:0] w_rem;
    logic [32:0] w_sum_by;
    logic        w_by_ovf;
    logic [31:0] w_move_tgt;
    logic        w_prof_bad;
    logic [7:0]  w_part_adv;
    logic [7:0]  w_adv;
    logic [31:0] w_pos_adv;
    logic [DIV_NUM_W-1:0] w_n_q;
    logic [7:0]  w_n;
    logic [16:0] w_period;
    logic [33:0] w_brk_lim;
    logic [32:0] w_rate_up;

    stsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // derive idle mode, distances and clamps
    always_comb begin
        n_en    = r_en;
        n_known = r_known;
        if (i_cfg_idx == CFG_MOTOR_EN)  n_en    = i_cfg_data[0];
        if (i_cfg_idx == CFG_POS_KNOWN) n_known = i_cfg_data[0];
        w_idle_mode     = (r_en && r_known) ? M_READY : M_DISABLED;
        n_cfg_idle_mode = (n_en && n_known) ? M_READY : M_DISABLED;
        w_busy = (r_mode == M_MOVING) || (r_mode == M_STOPPING);

        w_diff = {r_tgt[31], r_tgt} - {r_pos[31], r_pos};
        w_rem  = w_diff[32] ? 32'(-w_diff) : w_diff[31:0];

        w_sum_by   = {r_pos[31], r_pos} + {r_offs[31], r_offs};
        w_by_ovf   = (w_sum_by[32] != w_sum_by[31]);
        w_move_tgt = (r_op == OP_MOVE_BY) ? w_sum_by[31:0] : r_tpos;
        w_prof_bad = (32'(r_start_rate) < 32'(MIN_STEP_RATE))
                  || (32'(r_start_rate) > 32'(MAX_STEP_RATE))
                  || (r_max_rate < r_start_rate)
                  || (32'(r_max_rate) > 32'(MAX_STEP_RATE))
                  || (r_accel == '0);

        w_part_adv = (r_part < r_seg_len) ? r_part : r_seg_len;
        w_adv      = (r_op == OP_ESTOP) ? w_part_adv : r_seg_len;
        w_pos_adv  = r_dir ? (r_pos + 32'(w_adv)) : (r_pos - 32'(w_adv));

        // segment length clamp
        w_n_q = (w_quot == '0) ? DIV_NUM_W'(1) : w_quot;
        if (w_n_q > DIV_NUM_W'(MAX_SEGMENT_STEPS)) w_n_q = DIV_NUM_W'(MAX_SEGMENT_STEPS);
        if (w_n_q > DIV_NUM_W'(w_rem))             w_n_q = DIV_NUM_W'(w_rem);
        w_n = w_n_q[7:0];

        // period clamp
        if (w_quot < DIV_NUM_W'(2))          w_period = 17'd2;
        else if (w_quot > DIV_NUM_W'(65536)) w_period = 17'd65536;
        else                                 w_period = w_quot[16:0];

        w_brk_lim = {1'b0, r_bd} + 34'(r_seg_len);
        w_rate_up = 33'(r_rate) + {1'b0, r_delta};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_start_rate <= 16'd100;
            r_max_rate   <= 16'd1000;
            r_accel      <= 24'd1000;
            r_en         <= 1'b0;
            r_known      <= 1'b0;
            r_p_start    <= 16'd100;
            r_p_max      <= 16'd1000;
            r_p_accel    <= 24'd1000;
            r_mode       <= M_DISABLED;
            r_pos        <= '0;
            r_tgt        <= '0;
            r_dir        <= 1'b1;
            r_rate       <= '0;
            r_seg_len    <= '0;
            r_stop       <= 1'b0;
            r_run        <= 1'b0;
            r_div_go     <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (r_ov && o_out.ready) r_ov <= 1'b0;

            // register write; the user writes only while the planner is quiet, the block does not enforce it
            if (i_cfg_we && (i_cfg_idx <= CFG_POS_KNOWN)) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_START_RATE:   r_start_rate <= i_cfg_data[15:0];
                    CFG_MAX_RATE:     r_max_rate   <= i_cfg_data[15:0];
                    CFG_ACCELERATION: r_accel      <= i_cfg_data;
                    CFG_MOTOR_EN:     r_en         <= i_cfg_data[0];
                    default:          r_known      <= i_cfg_data[0];
                endcase
                if (w_busy) begin
                    if (!n_en) begin
                        r_tgt     <= r_pos;
                        r_rate    <= '0;
                        r_stop    <= 1'b0;
                        r_run     <= 1'b0;
                        r_seg_len <= '0;
                        r_mode    <= n_cfg_idle_mode;
                    end
                end else begin
                    r_mode <= n_cfg_idle_mode;
                end
            end

            unique case (r_state)
                // take an event
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op      <= i_in.op;
                        r_tpos    <= i_in.target_position;
                        r_offs    <= i_in.step_offset;
                        r_part    <= i_in.partial_steps;
                        r_status  <= ST_OK;
                        r_started <= 1'b0;
                        r_steps   <= '0;
                        r_period  <= '0;
                        r_state   <= S_DECODE;
                    end
                end

                // dispatch on the operation
                S_DECODE: begin
                    r_state <= S_OUT;
                    unique case (r_op)
                        OP_MOVE_TO, OP_MOVE_BY: begin
                            if (w_busy)                            r_status <= ST_BUSY;
                            else if (r_op == OP_MOVE_BY && w_by_ovf) r_status <= ST_INVALID;
                            else if (w_prof_bad)                   r_status <= ST_INVALID;
                            else if (!r_en)                        r_status <= ST_DISABLED;
                            else if (!r_known)                     r_status <= ST_NOT_READY;
                            else if (w_move_tgt == r_pos)          r_tgt    <= w_move_tgt;
                            else begin
                                r_p_start <= r_start_rate;
                                r_p_max   <= r_max_rate;
                                r_p_accel <= r_accel;
                                r_tgt     <= w_move_tgt;
                                r_dir     <= ($signed(w_move_tgt) > $signed(r_pos));
                                r_rate    <= r_start_rate;
                                r_stop    <= 1'b0;
                                r_mode    <= M_MOVING;
                                r_state   <= S_LN_GO;
                            end
                        end
                        OP_STOP: begin
                            if (w_busy) begin
                                r_stop <= 1'b1;
                                r_mode <= M_STOPPING;
                            end else begin
                                r_status <= ST_IGNORED;
                            end
                        end
                        OP_ESTOP: begin
                            r_pos     <= r_run ? w_pos_adv : r_pos;
                            r_tgt     <= r_run ? w_pos_adv : r_pos;
                            r_rate    <= '0;
                            r_stop    <= 1'b0;
                            r_run     <= 1'b0;
                            r_seg_len <= '0;
                            r_mode    <= w_idle_mode;
                        end
                        OP_SEGMENT_DONE: begin
                            if (r_run) begin
                                r_run   <= 1'b0;
                                r_pos   <= w_pos_adv;
                                r_state <= S_SD_CHK;
                            end else begin
                                r_status <= ST_IGNORED;
                            end
                        end
                        OP_SET_POSITION: begin
                            if (!r_known)    r_status <= ST_NOT_READY;
                            else if (w_busy) r_status <= ST_BUSY;
                            else begin
                                r_pos <= r_tpos;
                                r_tgt <= r_tpos;
                            end
                        end
                        default: r_status <= ST_IGNORED;
                    endcase
                end

                // end of segment: arrived, or form the rate step
                S_SD_CHK: begin
                    if (w_rem == '0) begin
                        r_rate    <= '0;
                        r_stop    <= 1'b0;
                        r_seg_len <= '0;
                        r_mode    <= w_idle_mode;
                        r_state   <= S_OUT;
                    end else if (r_rate == '0) begin
                        r_delta <= 32'd1;
                        r_state <= S_DLT_USE;
                    end else begin
                        r_prod  <= r_p_accel * r_seg_len;
                        r_state <= S_DLT_MUL;
                    end
                end

                S_DLT_MUL: begin
                    r_div_go  <= 1'b1;
                    r_div_num <= DIV_NUM_W'(r_prod);
                    r_div_den <= DIV_DEN_W'(r_rate);
                    r_state   <= S_DLT_DIV;
                end

                S_DLT_DIV: begin
                    if (w_div_done) begin
                        r_delta <= (w_quot == '0) ? 32'd1 : w_quot[31:0];
                        r_state <= S_DLT_USE;
                    end
                end

                // pending stop brakes directly; otherwise get braking distance
                S_DLT_USE: begin
                    if (r_stop) begin
                        r_mode <= M_STOPPING;
                        if (r_rate <= r_p_start || 32'(r_rate - r_p_start) <= r_delta) begin
                            r_tgt     <= r_pos;
                            r_rate    <= '0;
                            r_stop    <= 1'b0;
                            r_seg_len <= '0;
                            r_mode    <= w_idle_mode;
                            r_state   <= S_OUT;
                        end else begin
                            r_rate  <= r_rate - r_delta[15:0];
                            r_state <= S_LN_GO;
                        end
                    end else if (r_rate <= r_p_start || r_p_accel == '0) begin
                        r_bd    <= '0;
                        r_state <= S_BRK_USE;
                    end else begin
                        r_sq_rate  <= r_rate * r_rate;
                        r_sq_start <= r_p_start * r_p_start;
                        r_state    <= S_BRK_MUL;
                    end
                end

                S_BRK_MUL: begin
                    r_div_go  <= 1'b1;
                    r_div_num <= DIV_NUM_W'(33'(r_sq_rate - r_sq_start)
                                 + {8'd0, r_p_accel, 1'b0} - 33'd1);
                    r_div_den <= {r_p_accel, 1'b0};
                    r_state   <= S_BRK_DIV;
                end

                S_BRK_DIV: begin
                    if (w_div_done) begin
                        r_bd    <= w_quot[32:0];
                        r_state <= S_BRK_USE;
                    end
                end

                // brake or accelerate
                S_BRK_USE: begin
                    if (34'(w_rem) <= w_brk_lim) begin
                        r_mode <= M_STOPPING;
                        if (r_rate > r_p_start && 32'(r_rate - r_p_start) > r_delta)
                            r_rate <= r_rate - r_delta[15:0];
                        else
                            r_rate <= r_p_start;
                    end else begin
                        r_mode <= M_MOVING;
                        if (r_rate < r_p_max)
                            r_rate <= (w_rate_up > 33'(r_p_max)) ? r_p_max : w_rate_up[15:0];
                    end
                    r_state <= S_LN_GO;
                end

                // launch: pulse count first
                S_LN_GO: begin
                    if (r_rate == '0) begin
                        r_rate    <= '0;
                        r_stop    <= 1'b0;
                        r_seg_len <= '0;
                        r_mode    <= w_idle_mode;
                        r_state   <= S_OUT;
                    end else begin
                        r_div_go  <= 1'b1;
                        r_div_num <= DIV_NUM_W'(r_rate) + DIV_NUM_W'(HALF_CTL);
                        r_div_den <= DIV_DEN_W'(CONTROL_HZ);
                        r_state   <= S_LN_CNT;
                    end
                end

                S_LN_CNT: begin
                    if (w_div_done) begin
                        if (w_n == '0) begin
                            r_rate    <= '0;
                            r_stop    <= 1'b0;
                            r_seg_len <= '0;
                            r_mode    <= w_idle_mode;
                            r_state   <= S_OUT;
                        end else begin
                            r_steps   <= w_n;
                            r_div_go  <= 1'b1;
                            r_div_num <= DIV_NUM_W'(PULSE_CLOCK_HZ)
                                         + DIV_NUM_W'(r_rate[15:1]);
                            r_div_den <= DIV_DEN_W'(r_rate);
                            r_state   <= S_LN_PER;
                        end
                    end
                end

                S_LN_PER: begin
                    if (w_div_done) begin
                        r_period  <= w_period;
                        r_seg_len <= r_steps;
                        r_run     <= 1'b1;
                        r_started <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end

                // hand the result to the output register
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_status;
                        r_o_mode   <= r_mode;
                        r_o_dir    <= r_dir;
                        r_o_start  <= r_started;
                        r_o_steps  <= r_started ? r_steps : 8'd0;
                        r_o_period <= r_started ? r_period : 17'd0;
                        r_o_rate   <= r_rate;
                        r_o_pos    <= r_pos;
                        r_o_tgt    <= r_tgt;
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ov;
    assign o_out.status        = r_o_status;
    assign o_out.motor_state   = r_o_mode;
    assign o_out.direction     = r_o_dir;
    assign o_out.segment_start = r_o_start;
    assign o_out.segment_steps = r_o_steps;
    assign o_out.period_ticks  = r_o_period;
    assign o_out.step_rate     = r_o_rate;
    assign o_out.position      = r_o_pos;
    assign o_out.target        = r_o_tgt;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment planner testbench
// Drives motion events and profile register writes into the planner. A
// cycle-free copy of the planner state predicts each result, and a scoreboard
// compares every result transaction field by field in order.
// ----------------------------------------------------------------------------
module tb;
    import stsp_pkg::*;

    localparam int      HALF_PERIOD   = 5;
    localparam int      DRAIN_CYCLES  = 200;
    localparam int      STALL_LIMIT   = 5000;
    localparam int      EVENT_TARGET  = 850;
    localparam int      PULSE_HZ      = PULSE_CLOCK_HZ_DEF;
    localparam int      CTRL_HZ       = CONTROL_HZ_DEF;
    localparam int      SEG_MAX       = MAX_SEGMENT_STEPS_DEF;
    localparam int      RATE_MIN      = MIN_STEP_RATE_DEF;
    localparam int      RATE_MAX      = MAX_STEP_RATE_DEF;
    localparam logic [2:0] OP_UNUSED6 = 3'd6;
    localparam logic [2:0] OP_UNUSED7 = 3'd7;
    localparam logic [2:0] CFG_NONE   = 3'd5;

    typedef struct packed {
        t_status            status;
        t_mode              mstate;
        logic               dir;
        logic               seg_start;
        logic [7:0]         seg_steps;
        logic [16:0]        period;
        logic [15:0]        rate;
        logic [31:0]        pos;
        logic [31:0]        tgt;
    } t_plan_result;

    // Planner state copy plus queue of expected results
    class t_plan_scoreboard;
        bit [15:0]    reg_start, reg_max;
        bit [23:0]    reg_accel;
        bit           reg_en, reg_known;
        bit [15:0]    run_start, run_max;
        bit [23:0]    run_accel;
        t_mode        mode;
        bit [31:0]    pos, tgt, rate;
        bit           dir_pos, stop_pend, seg_run;
        bit [7:0]     seg_len;
        t_plan_result expected[$];
        int           errors, mismatches;

        function void reset();
            reg_start = 16'd100; reg_max = 16'd1000; reg_accel = 24'd1000;
            reg_en = 0; reg_known = 0;
            run_start = reg_start; run_max = reg_max; run_accel = reg_accel;
            mode = M_DISABLED; pos = 0; tgt = 0; dir_pos = 1; rate = 0;
            seg_len = 0; stop_pend = 0; seg_run = 0;
            expected.delete(); errors = 0; mismatches = 0;
        endfunction

        function t_mode idle_mode();
            return (reg_en && reg_known) ? M_READY : M_DISABLED;
        endfunction

        function bit is_busy();
            return mode == M_MOVING || mode == M_STOPPING;
        endfunction

        function longint unsigned steps_left();
            longint d;
            d = longint'($signed(tgt)) - longint'($signed(pos));
            return (d < 0) ? -d : d;
        endfunction

        function void go_idle();
            rate = 0; stop_pend = 0; seg_run = 0; seg_len = 0;
            mode = idle_mode();
        endfunction

        function bit launch(output bit [7:0] steps, output bit [16:0] period);
            longint unsigned rem, n, p;
            rem = steps_left();
            n = (rate + CTRL_HZ / 2) / CTRL_HZ;
            if (n == 0) n = 1;
            if (n > SEG_MAX) n = SEG_MAX;
            if (n > rem) n = rem;
            steps = 0; period = 0;
            if (n == 0 || rate == 0) begin
                go_idle();
                return 0;
            end
            p = (longint'(PULSE_HZ) + rate / 2) / rate;
            if (p < 2) p = 2;
            if (p > 65536) p = 65536;
            seg_len = 8'(n); seg_run = 1;
            steps = 8'(n); period = 17'(p);
            return 1;
        endfunction

        function bit [31:0] rate_step();
            longint unsigned d;
            if (rate == 0) return 1;
            d = (longint'(run_accel) * seg_len) / rate;
            if (d == 0) d = 1;
            if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
            return 32'(d);
        endfunction

        function longint unsigned brake_steps();
            longint unsigned den;
            if (rate <= run_start || run_accel == 0) return 0;
            den = 2 * longint'(run_accel);
            return (longint'(rate) * rate - longint'(run_start) * run_start + den - 1) / den;
        endfunction

        function void advance(bit [31:0] n);
            if (dir_pos) pos = pos + n;
            else pos = pos - n;
        endfunction

        function bit end_segment(output bit [7:0] steps, output bit [16:0] period);
            longint unsigned rem, nx;
            bit [31:0] delta;
            steps = 0; period = 0;
            seg_run = 0;
            advance(32'(seg_len));
            rem = steps_left();
            if (rem == 0) begin
                go_idle();
                return 0;
            end
            delta = rate_step();
            if (stop_pend) begin
                mode = M_STOPPING;
                if (rate <= run_start || rate - run_start <= delta) begin
                    tgt = pos;
                    go_idle();
                    return 0;
                end
                rate = rate - delta;
            end else if (rem <= brake_steps() + seg_len) begin
                mode = M_STOPPING;
                if (rate > run_start && rate - run_start > delta) rate = rate - delta;
                else rate = 32'(run_start);
            end else begin
                mode = M_MOVING;
                if (rate < run_max) begin
                    nx = longint'(rate) + delta;
                    if (nx > run_max) nx = run_max;
                    rate = 32'(nx);
                end
            end
            return launch(steps, period);
        endfunction

        function t_status begin_move(bit [31:0] dest, output bit started,
                                     output bit [7:0] steps, output bit [16:0] period);
            started = 0; steps = 0; period = 0;
            if (reg_start < RATE_MIN || reg_start > RATE_MAX || reg_max < reg_start ||
                reg_max > RATE_MAX || reg_accel == 0)
                return ST_INVALID;
            if (!reg_en) return ST_DISABLED;
            if (!reg_known) return ST_NOT_READY;
            if (dest == pos) begin
                tgt = dest;
                return ST_OK;
            end
            run_start = reg_start; run_max = reg_max; run_accel = reg_accel;
            tgt = dest;
            dir_pos = ($signed(dest) > $signed(pos));
            rate = 32'(run_start); stop_pend = 0; mode = M_MOVING;
            started = launch(steps, period);
            return ST_OK;
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] data);
            case (idx)
                CFG_START_RATE:   reg_start = data[15:0];
                CFG_MAX_RATE:     reg_max = data[15:0];
                CFG_ACCELERATION: reg_accel = data;
                CFG_MOTOR_EN:     reg_en = data[0];
                CFG_POS_KNOWN:    reg_known = data[0];
                default:          return;
            endcase
            if (is_busy()) begin
                if (!reg_en) begin
                    tgt = pos;
                    go_idle();
                end
            end else begin
                mode = idle_mode();
            end
        endfunction

        // Work out the result of one accepted event
        function void note_event(logic [2:0] op, logic [31:0] tpos, logic [31:0] offs,
                                 logic [7:0] part);
            t_plan_result r;
            t_status st;
            bit started;
            bit [7:0] steps;
            bit [16:0] period;
            longint t;
            st = ST_OK; started = 0; steps = 0; period = 0;
            case (op)
                OP_MOVE_TO: begin
                    if (is_busy()) st = ST_BUSY;
                    else st = begin_move(tpos, started, steps, period);
                end
                OP_MOVE_BY: begin
                    t = longint'($signed(pos)) + longint'($signed(offs));
                    if (is_busy()) st = ST_BUSY;
                    else if (t < -64'sh8000_0000 || t > 64'sh7FFF_FFFF) st = ST_INVALID;
                    else st = begin_move(t[31:0], started, steps, period);
                end
                OP_STOP: begin
                    if (is_busy()) begin
                        stop_pend = 1;
                        mode = M_STOPPING;
                    end else begin
                        st = ST_IGNORED;
                    end
                end
                OP_ESTOP: begin
                    if (seg_run) advance(32'((part < seg_len) ? part : seg_len));
                    tgt = pos;
                    go_idle();
                end
                OP_SEGMENT_DONE: begin
                    if (seg_run) started = end_segment(steps, period);
                    else st = ST_IGNORED;
                end
                OP_SET_POSITION: begin
                    if (!reg_known) st = ST_NOT_READY;
                    else if (is_busy()) st = ST_BUSY;
                    else begin
                        pos = tpos;
                        tgt = tpos;
                    end
                end
                default: st = ST_IGNORED;
            endcase
            if (!started) begin
                steps = 0;
                period = 0;
            end
            r.status = st; r.mstate = mode; r.dir = dir_pos; r.seg_start = started;
            r.seg_steps = steps; r.period = period; r.rate = rate[15:0];
            r.pos = pos; r.tgt = tgt;
            expected.push_back(r);
        endfunction

        // Compare one result transaction against the oldest expectation
        function void check_result(t_plan_result got);
            t_plan_result exp_r;
            if (expected.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result %p", got);
                return;
            end
            exp_r = expected.pop_front();
            if (got.status !== exp_r.status || got.mstate !== exp_r.mstate ||
                got.dir !== exp_r.dir || got.seg_start !== exp_r.seg_start ||
                got.seg_steps !== exp_r.seg_steps || got.period !== exp_r.period ||
                got.rate !== exp_r.rate || got.pos !== exp_r.pos || got.tgt !== exp_r.tgt) begin
                errors++;
                if (mismatches++ < 10)
                    $display("result mismatch\n  expected %p\n  actual   %p", exp_r, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    stsp_in_if  ev_if ();
    stsp_out_if res_if ();

    stepper_trapezoid_segment_planner_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (ev_if.sink),
        .o_out      (res_if.source)
    );

    t_plan_scoreboard sb;
    int events_sent;
    int quiet_cycles;
    int hold_left;
    bit hold_done;

    // No idling on either side through this stretch of events
    function automatic bit calm_stretch();
        return events_sent >= 450 && events_sent < 580;
    endfunction

    function automatic bit want_gap();
        return !calm_stretch() && $urandom_range(99) < 11;
    endfunction

    // Free-running clock
    initial i_clk = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    // Send one event and note it once the transaction completes
    task automatic send_event(logic [2:0] op, logic [31:0] tpos, logic [31:0] offs,
                              logic [7:0] part);
        while (want_gap()) begin
            ev_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        ev_if.valid <= 1'b1;
        ev_if.op <= op;
        ev_if.target_position <= tpos;
        ev_if.step_offset <= offs;
        ev_if.partial_steps <= part;
        do @(posedge i_clk); while (!ev_if.ready);
        sb.note_event(op, tpos, offs, part);
        events_sent++;
        @(negedge i_clk);
    endtask

    // Let all results drain before touching the registers
    task automatic settle();
        ev_if.valid <= 1'b0;
        while (sb.expected.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write one register, then drop the enable for a cycle
    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_profile(logic [15:0] start_r, logic [15:0] max_r, logic [23:0] accel,
                                 logic en, logic known);
        write_reg(CFG_START_RATE, {8'(0), start_r});
        write_reg(CFG_MAX_RATE, {8'(0), max_r});
        write_reg(CFG_ACCELERATION, accel);
        write_reg(CFG_MOTOR_EN, {23'd0, en});
        write_reg(CFG_POS_KNOWN, {23'd0, known});
    endtask

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(5))
            0: return 16'd1;
            1: return 16'd100;
            2: return 16'(RATE_MAX);
            3: return 16'hFFFF;
            default: return 16'($urandom_range(RATE_MAX, 1));
        endcase
    endfunction

    function automatic logic [23:0] pick_accel();
        case ($urandom_range(6))
            0: return 24'd1;
            1: return 24'hFF_FFFF;
            2: return 24'd0;
            3: return 24'd1000;
            default: return 24'($urandom_range(200000, 50));
        endcase
    endfunction

    // Mostly well-formed moves run to completion, with noise mixed in
    task automatic random_phase(int count);
        int k;
        int sel;
        logic [31:0] span;
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            span = $urandom_range(3000, 1);
            if ($urandom_range(1)) span = -span;
            if (sb.seg_run) begin
                if (sel < 80)
                    send_event(OP_SEGMENT_DONE, $urandom, $urandom, 8'($urandom));
                else if (sel < 85)
                    send_event(OP_STOP, $urandom, $urandom, 8'($urandom));
                else if (sel < 88)
                    send_event(OP_ESTOP, $urandom, $urandom, 8'($urandom_range(255)));
                else if (sel < 92)
                    send_event(OP_MOVE_BY, $urandom, span, 8'($urandom));
                else if (sel < 95)
                    send_event(OP_SET_POSITION, $urandom, $urandom, 8'($urandom));
                else
                    send_event(3'($urandom_range(7)), $urandom, $urandom, 8'($urandom));
            end else begin
                if (sel < 40)
                    send_event(OP_MOVE_BY, $urandom, span, 8'($urandom));
                else if (sel < 70)
                    send_event(OP_MOVE_TO, sb.pos + span, $urandom, 8'($urandom));
                else if (sel < 76)
                    send_event(OP_MOVE_BY, $urandom, $urandom, 8'($urandom));
                else if (sel < 82)
                    send_event(OP_SET_POSITION, $urandom, $urandom, 8'($urandom));
                else if (sel < 86)
                    send_event(OP_MOVE_TO, $urandom, $urandom, 8'($urandom));
                else
                    send_event(3'($urandom_range(7)), $urandom, $urandom,
                               8'($urandom_range(255)));
            end
        end
    endtask

    // Stimulus
    initial begin
        sb = new();
        sb.reset();
        events_sent = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        ev_if.valid = 1'b0;
        ev_if.op = OP_MOVE_TO;
        ev_if.target_position = '0;
        ev_if.step_offset = '0;
        ev_if.partial_steps = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Motor disabled and position unknown
        send_event(OP_MOVE_TO, 32'd5, 32'd0, 8'd0);
        send_event(OP_SET_POSITION, 32'd7, 32'd0, 8'd0);
        send_event(OP_STOP, 32'd0, 32'd0, 8'd0);
        send_event(OP_SEGMENT_DONE, 32'd0, 32'd0, 8'd0);
        send_event(OP_ESTOP, 32'd0, 32'd0, 8'd160);
        send_event(OP_UNUSED6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_event(OP_UNUSED7, 32'd0, 32'd0, 8'd0);
        settle();
        write_reg(CFG_MOTOR_EN, 24'd1);
        write_reg(CFG_NONE, 24'hFF_FFFF);
        send_event(OP_MOVE_BY, 32'd0, 32'd10, 8'd0);
        settle();
        write_reg(CFG_POS_KNOWN, 24'd1);

        // Move-by overflow, move to the current position, short moves
        send_event(OP_SET_POSITION, 32'h7FFF_FFF0, 32'd0, 8'd0);
        send_event(OP_MOVE_BY, 32'd0, 32'h7FFF_FFFF, 8'd0);
        send_event(OP_SET_POSITION, 32'h8000_0000, 32'd0, 8'd0);
        send_event(OP_MOVE_BY, 32'd0, 32'h8000_0000, 8'd0);
        send_event(OP_MOVE_TO, 32'h8000_0000, 32'd0, 8'd0);
        send_event(OP_SET_POSITION, 32'd0, 32'd0, 8'd0);
        send_event(OP_MOVE_TO, 32'd40, 32'd0, 8'd0);
        send_event(OP_MOVE_TO, 32'd90, 32'd0, 8'd0);
        send_event(OP_SET_POSITION, 32'd9, 32'd0, 8'd0);
        send_event(OP_SEGMENT_DONE, 32'd0, 32'd0, 8'd0);
        send_event(OP_STOP, 32'd0, 32'd0, 8'd0);
        while (sb.seg_run) send_event(OP_SEGMENT_DONE, 32'd0, 32'd0, 8'd0);
        send_event(OP_MOVE_BY, 32'd0, -32'sd500, 8'd0);
        send_event(OP_ESTOP, 32'd0, 32'd0, 8'd255);
        send_event(OP_MOVE_TO, 32'd300, 32'd0, 8'd0);
        send_event(OP_ESTOP, 32'd0, 32'd0, 8'd0);

        // Invalid profiles, then a move left running when the motor drops
        settle();
        write_profile(16'd0, 16'd1000, 24'd1000, 1'b1, 1'b1);
        send_event(OP_MOVE_BY, 32'd0, 32'd10, 8'd0);
        settle();
        write_profile(16'd500, 16'd400, 24'd0, 1'b1, 1'b1);
        send_event(OP_MOVE_BY, 32'd0, 32'd10, 8'd0);
        settle();
        write_profile(16'hFFFF, 16'hFFFF, 24'd1000, 1'b1, 1'b1);
        send_event(OP_MOVE_BY, 32'd0, 32'd10, 8'd0);
        settle();
        write_profile(16'd100, 16'd1000, 24'd1000, 1'b1, 1'b1);
        send_event(OP_MOVE_BY, 32'd0, 32'd5000, 8'd0);
        send_event(OP_SEGMENT_DONE, 32'd0, 32'd0, 8'd0);
        settle();
        write_reg(CFG_MOTOR_EN, 24'd0);

        // Random phases, each with its own profile
        while (events_sent < EVENT_TARGET) begin
            settle();
            if ($urandom_range(3) == 0)
                write_profile(16'd1, 16'(RATE_MAX), 24'hFF_FFFF, 1'b1, 1'b1);
            else if ($urandom_range(3) == 0)
                write_profile(16'(RATE_MAX), 16'(RATE_MAX), 24'd1, 1'b1, 1'b1);
            else write_profile(pick_rate(), pick_rate(), pick_accel(),
                               $urandom_range(9) != 0, $urandom_range(9) != 0);
            random_phase($urandom_range(90, 40));
        end

        ev_if.valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.errors += sb.expected.size();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side ready, with one long hold-off while events keep coming
    initial begin
        res_if.ready = 1'b0;
        hold_left = 0;
        hold_done = 0;
    end

    always @(negedge i_clk) begin
        if (!hold_done && events_sent >= 250) begin
            hold_done <= 1'b1;
            hold_left <= 600;
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !want_gap();
        end
    end

    // Check each result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result('{t_status'(res_if.status), t_mode'(res_if.motor_state),
                              res_if.direction, res_if.segment_start, res_if.segment_steps,
                              res_if.period_ticks, res_if.step_rate, res_if.position,
                              res_if.target});
        end
    end

    // Watchdog on cycles without any transaction
    initial quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
